// ----- rtl/dcsw_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and constants of the two-channel stop-and-wait sender
// no dependencies
package dcsw_pkg;

	localparam int CHANNELS_DEF = 2;
	localparam int FILE_LEN_W = 32;
	localparam int CHUNK_W = 16;
	localparam int TIMER_W = 24;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_STEPS = FILE_LEN_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [FILE_LEN_W-1:0] FILE_LEN_RST = '0;
	localparam logic [CHUNK_W-1:0] CHUNK_RST = 16'd1024;
	localparam logic [TIMER_W-1:0] TIMEOUT_RST = 24'd1000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FILE_LENGTH = 2'd0,
		CFG_CHUNK_BYTES = 2'd1,
		CFG_TIMEOUT_TICKS = 2'd2,
		CFG_UNUSED = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_TICK = 2'd1,
		REQ_ACK = 2'd2,
		REQ_NONE = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		KIND_NEW = 2'd0,
		KIND_RESEND = 2'd1,
		KIND_TERM = 2'd2
	} send_kind_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic ack_channel;
		logic ack_final;
	} req_t;

	typedef struct packed {
		logic send_channel;
		logic [FILE_LEN_W-1:0] send_offset;
		logic [CHUNK_W-1:0] send_size;
		logic send_final;
		logic [1:0] send_kind;
		logic transfer_done;
		logic run_end;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SEND0,
		ST_SEND1,
		ST_TICK0,
		ST_TICK1,
		ST_ACK,
		ST_TERM
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_DIV,
		OP_SEND0,
		OP_SEND1,
		OP_TICK0,
		OP_TICK1,
		OP_ACK,
		OP_TERM
	} op_t;

	typedef struct packed {
		op_t op;
		logic fire;
	} cmd_t;

	typedef struct packed {
		req_kind_t in_kind;
		logic tick_ok;
		logic ack_ok;
		logic div_last;
		logic emit;
		logic more;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/dcsw_stream_if.sv -----
`timescale 1ns / 1ps
// valid/ready stream channel carrying one payload struct per beat
// payload type is set by the instantiating level, typically from dcsw_pkg
interface dcsw_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/dcsw_ctrl.sv -----
`timescale 1ns / 1ps
// controller state machine of the stop-and-wait sender
// depends on dcsw_pkg; drives dcsw_dp through cmd_t, reads status_t
module dcsw_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input dcsw_pkg::status_t st,
	output dcsw_pkg::cmd_t cmd
);

	dcsw_pkg::state_t state_q;
	dcsw_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcsw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dcsw_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (st.in_kind)
						dcsw_pkg::REQ_START: state_d = dcsw_pkg::ST_DIV;
						dcsw_pkg::REQ_TICK:
							state_d = st.tick_ok ? dcsw_pkg::ST_TICK0 : dcsw_pkg::ST_IDLE;
						dcsw_pkg::REQ_ACK:
							state_d = st.ack_ok ? dcsw_pkg::ST_ACK : dcsw_pkg::ST_IDLE;
						dcsw_pkg::REQ_NONE: state_d = dcsw_pkg::ST_IDLE;
						default: state_d = dcsw_pkg::ST_IDLE;
					endcase
				end
			end
			dcsw_pkg::ST_DIV: begin
				if (st.div_last) begin
					state_d = dcsw_pkg::ST_SEND0;
				end
			end
			dcsw_pkg::ST_SEND0: begin
				if (cmd.fire) begin
					state_d = st.more ? dcsw_pkg::ST_SEND1 : dcsw_pkg::ST_IDLE;
				end
			end
			dcsw_pkg::ST_TICK0: begin
				if (cmd.fire) begin
					state_d = st.more ? dcsw_pkg::ST_TICK1 : dcsw_pkg::ST_IDLE;
				end
			end
			dcsw_pkg::ST_ACK: begin
				if (cmd.fire) begin
					state_d = st.more ? dcsw_pkg::ST_TERM : dcsw_pkg::ST_IDLE;
				end
			end
			dcsw_pkg::ST_SEND1, dcsw_pkg::ST_TICK1, dcsw_pkg::ST_TERM: begin
				if (cmd.fire) begin
					state_d = dcsw_pkg::ST_IDLE;
				end
			end
			default: state_d = dcsw_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd.op = dcsw_pkg::OP_NONE;
		unique case (state_q)
			dcsw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.op = in_valid ? dcsw_pkg::OP_ACCEPT : dcsw_pkg::OP_NONE;
			end
			dcsw_pkg::ST_DIV: cmd.op = dcsw_pkg::OP_DIV;
			dcsw_pkg::ST_SEND0: cmd.op = dcsw_pkg::OP_SEND0;
			dcsw_pkg::ST_SEND1: cmd.op = dcsw_pkg::OP_SEND1;
			dcsw_pkg::ST_TICK0: cmd.op = dcsw_pkg::OP_TICK0;
			dcsw_pkg::ST_TICK1: cmd.op = dcsw_pkg::OP_TICK1;
			dcsw_pkg::ST_ACK: cmd.op = dcsw_pkg::OP_ACK;
			dcsw_pkg::ST_TERM: cmd.op = dcsw_pkg::OP_TERM;
			default: cmd.op = dcsw_pkg::OP_NONE;
		endcase
		// a step that emits waits for room in the output register
		cmd.fire = (cmd.op != dcsw_pkg::OP_NONE) && (!st.emit || st.out_free);
	end

endmodule

// ----- rtl/dcsw_dp.sv -----
`timescale 1ns / 1ps
// datapath of the stop-and-wait sender: config registers, divider, chunk and
// timer state, output register; depends on dcsw_pkg, steered by dcsw_ctrl
module dcsw_dp #(
	parameter int CHANNELS = dcsw_pkg::CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [dcsw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [dcsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input dcsw_pkg::req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output dcsw_pkg::rsp_t out_data,
	input dcsw_pkg::cmd_t cmd,
	output dcsw_pkg::status_t st
);

	localparam int FW = dcsw_pkg::FILE_LEN_W;
	localparam int CW = dcsw_pkg::CHUNK_W;
	localparam int TW = dcsw_pkg::TIMER_W;
	localparam logic MULTI = (CHANNELS > 1);

	// configuration
	logic [FW-1:0] file_length_q;
	logic [CW-1:0] chunk_bytes_q;
	logic [TW-1:0] timeout_ticks_q;

	// transfer state
	logic [FW-1:0] next_offset_q;
	logic end_reached_q;
	logic [FW-1:0] acks_remaining_q;
	logic finished_q;
	logic [FW-1:0] held_offset_q [2];
	logic [CW-1:0] held_size_q [2];
	logic held_final_q [2];
	logic [TW-1:0] channel_timer_q [2];
	logic timer_running_q [2];

	// latched request and divider
	logic ack_channel_q;
	logic ack_final_q;
	logic [FW-1:0] quo_q;
	logic [CW-1:0] rem_q;
	logic [dcsw_pkg::DIV_CNT_W-1:0] div_cnt_q;

	logic out_valid_q;
	dcsw_pkg::rsp_t out_data_q;

	logic [CW-1:0] c_eff;
	logic [TW-1:0] reload;
	logic [CW:0] div_shift;
	logic div_ge;
	logic [CW:0] div_sub;
	logic [FW:0] diff;
	logic borrow;
	logic diff_short;
	logic [CW-1:0] size;
	logic short;
	logic end_after;
	logic size_nz;
	logic two_chunks;
	logic send_ch;
	logic tick_ch;
	logic expire [2];
	logic chunk_path;
	logic term;
	logic fl_zero;
	dcsw_pkg::rsp_t rsp_d;

	assign c_eff = (chunk_bytes_q == '0) ? CW'(1) : chunk_bytes_q;
	assign reload = (timeout_ticks_q == '0) ? TW'(1) : timeout_ticks_q;
	assign fl_zero = (file_length_q == '0);

	// one restoring step per cycle
	assign div_shift = {rem_q, quo_q[FW-1]};
	assign div_ge = (div_shift >= {1'b0, c_eff});
	assign div_sub = div_shift - {1'b0, c_eff};

	// chunk read at next_offset
	assign diff = {1'b0, file_length_q} - {1'b0, next_offset_q};
	assign borrow = diff[FW];
	assign diff_short = (diff[FW-1:0] < {{(FW-CW){1'b0}}, c_eff});
	assign size = borrow ? '0 : (diff_short ? diff[CW-1:0] : c_eff);
	assign short = borrow || diff_short;
	assign end_after = end_reached_q || short;
	assign size_nz = !borrow && (diff[FW-1:0] != '0);
	// a file of exactly one chunk leaves the second read empty
	assign two_chunks = MULTI && !end_after
		&& (diff[FW-1:0] != {{(FW-CW){1'b0}}, c_eff});

	assign tick_ch = (cmd.op == dcsw_pkg::OP_TICK1);
	assign expire[0] = timer_running_q[0] && (channel_timer_q[0] <= TW'(1));
	assign expire[1] = timer_running_q[1] && (channel_timer_q[1] <= TW'(1));
	assign chunk_path = !(ack_final_q || end_reached_q);
	assign term = (acks_remaining_q == FW'(1));

	always_comb begin
		case (cmd.op)
			dcsw_pkg::OP_SEND1: send_ch = 1'b1;
			dcsw_pkg::OP_ACK: send_ch = ack_channel_q;
			default: send_ch = 1'b0;
		endcase
	end

	// status toward the controller
	always_comb begin
		st.in_kind = dcsw_pkg::req_kind_t'(in_data.req_type);
		st.tick_ok = !finished_q;
		st.ack_ok = !finished_q && (acks_remaining_q != '0)
			&& (!in_data.ack_channel || MULTI);
		st.div_last = (div_cnt_q == dcsw_pkg::DIV_CNT_W'(dcsw_pkg::DIV_STEPS - 1));
		st.out_free = !out_valid_q || out_ready;
		st.emit = 1'b0;
		st.more = 1'b0;
		case (cmd.op)
			dcsw_pkg::OP_SEND0: begin
				st.emit = !fl_zero;
				st.more = !fl_zero && MULTI && !end_after;
			end
			dcsw_pkg::OP_SEND1: st.emit = size_nz;
			dcsw_pkg::OP_TICK0: begin
				st.emit = expire[0];
				st.more = MULTI;
			end
			dcsw_pkg::OP_TICK1: st.emit = expire[1];
			dcsw_pkg::OP_ACK: begin
				st.emit = chunk_path && size_nz;
				st.more = term;
			end
			dcsw_pkg::OP_TERM: st.emit = 1'b1;
			default: begin
				st.emit = 1'b0;
				st.more = 1'b0;
			end
		endcase
	end

	// result beat of the current step
	always_comb begin
		rsp_d.send_channel = send_ch;
		rsp_d.send_offset = next_offset_q;
		rsp_d.send_size = size;
		rsp_d.send_final = end_after;
		rsp_d.send_kind = dcsw_pkg::KIND_NEW;
		rsp_d.transfer_done = 1'b0;
		rsp_d.run_end = 1'b1;
		case (cmd.op)
			dcsw_pkg::OP_SEND0: rsp_d.run_end = !two_chunks;
			dcsw_pkg::OP_ACK: begin
				rsp_d.transfer_done = term;
				rsp_d.run_end = !term;
			end
			dcsw_pkg::OP_TICK0, dcsw_pkg::OP_TICK1: begin
				rsp_d.send_channel = tick_ch;
				rsp_d.send_offset = held_offset_q[tick_ch];
				rsp_d.send_size = held_size_q[tick_ch];
				rsp_d.send_final = held_final_q[tick_ch];
				rsp_d.send_kind = dcsw_pkg::KIND_RESEND;
				rsp_d.run_end = tick_ch || !(MULTI && expire[1]);
			end
			dcsw_pkg::OP_TERM: begin
				rsp_d.send_channel = MULTI;
				rsp_d.send_size = '0;
				rsp_d.send_final = 1'b1;
				rsp_d.send_kind = dcsw_pkg::KIND_TERM;
				rsp_d.transfer_done = 1'b1;
			end
			default: rsp_d.run_end = 1'b1;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= dcsw_pkg::FILE_LEN_RST;
			chunk_bytes_q <= dcsw_pkg::CHUNK_RST;
			timeout_ticks_q <= dcsw_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (dcsw_pkg::cfg_index_t'(cfg_index))
				dcsw_pkg::CFG_FILE_LENGTH: file_length_q <= cfg_wdata[FW-1:0];
				dcsw_pkg::CFG_CHUNK_BYTES: chunk_bytes_q <= cfg_wdata[CW-1:0];
				dcsw_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata[TW-1:0];
				dcsw_pkg::CFG_UNUSED: file_length_q <= file_length_q;
				default: file_length_q <= file_length_q;
			endcase
		end
	end

	// divider and latched request fields
	always_ff @(posedge clk) begin
		if (cmd.fire && cmd.op == dcsw_pkg::OP_ACCEPT) begin
			ack_channel_q <= in_data.ack_channel;
			ack_final_q <= in_data.ack_final;
			quo_q <= file_length_q;
			rem_q <= '0;
		end else if (cmd.fire && cmd.op == dcsw_pkg::OP_DIV) begin
			quo_q <= {quo_q[FW-2:0], div_ge};
			rem_q <= div_ge ? div_sub[CW-1:0] : div_shift[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.fire && cmd.op == dcsw_pkg::OP_ACCEPT) begin
			div_cnt_q <= '0;
		end else if (cmd.fire && cmd.op == dcsw_pkg::OP_DIV) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_offset_q <= '0;
			end_reached_q <= 1'b0;
			acks_remaining_q <= '0;
			finished_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				held_offset_q[i] <= '0;
				held_size_q[i] <= '0;
				held_final_q[i] <= 1'b0;
				channel_timer_q[i] <= '0;
				timer_running_q[i] <= 1'b0;
			end
		end else if (cmd.fire) begin
			case (cmd.op)
				dcsw_pkg::OP_ACCEPT: begin
					if (in_data.req_type == dcsw_pkg::REQ_START) begin
						next_offset_q <= '0;
						end_reached_q <= 1'b0;
						finished_q <= 1'b0;
						for (int i = 0; i < 2; i++) begin
							channel_timer_q[i] <= '0;
							timer_running_q[i] <= 1'b0;
						end
					end
				end
				dcsw_pkg::OP_SEND0, dcsw_pkg::OP_SEND1, dcsw_pkg::OP_ACK: begin
					if (cmd.op == dcsw_pkg::OP_SEND0) begin
						acks_remaining_q <= quo_q + FW'(rem_q != '0);
					end
					if (cmd.op == dcsw_pkg::OP_ACK) begin
						acks_remaining_q <= acks_remaining_q - 1'b1;
					end
					if (cmd.op == dcsw_pkg::OP_SEND0 && fl_zero) begin
						end_reached_q <= 1'b1;
						finished_q <= 1'b1;
					end else if (cmd.op == dcsw_pkg::OP_ACK && !chunk_path) begin
						timer_running_q[send_ch] <= 1'b0;
					end else begin
						if (short) begin
							end_reached_q <= 1'b1;
						end
						if (!size_nz) begin
							timer_running_q[send_ch] <= 1'b0;
						end else begin
							held_offset_q[send_ch] <= next_offset_q;
							held_size_q[send_ch] <= size;
							held_final_q[send_ch] <= end_after;
							channel_timer_q[send_ch] <= reload;
							timer_running_q[send_ch] <= 1'b1;
							next_offset_q <= next_offset_q + FW'(size);
						end
					end
					// last ack closes the transfer and stops both timers
					if (cmd.op == dcsw_pkg::OP_ACK && term) begin
						finished_q <= 1'b1;
						for (int i = 0; i < 2; i++) begin
							timer_running_q[i] <= 1'b0;
						end
					end
				end
				dcsw_pkg::OP_TICK0, dcsw_pkg::OP_TICK1: begin
					if (timer_running_q[tick_ch]) begin
						if (expire[tick_ch]) begin
							channel_timer_q[tick_ch] <= reload;
						end else begin
							channel_timer_q[tick_ch] <= channel_timer_q[tick_ch] - 1'b1;
						end
					end
				end
				default: begin
					finished_q <= finished_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.fire && st.emit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire && st.emit) begin
			out_data_q <= rsp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

// ----- rtl/dual_channel_stop_and_wait_sender_unit.sv -----
`timescale 1ns / 1ps
// Two-channel stop-and-wait sender, descriptor level.
// Channels: req (sink) takes request beats: start, time tick or ack with its
// channel and final mark. rsp (source) gives send descriptors: channel,
// offset, size, final flag, kind (new, resend, terminator), transfer_done
// and run_end on the last beat caused by one request. Registers file_length,
// chunk_bytes and timeout_ticks are written through cfg_we/cfg_index/
// cfg_wdata; the user must write them only while the block is idle, which
// the block itself does not enforce. A request is taken in the idle state,
// then the block runs one step per result: a tick steps channel 0 and, with
// two channels, channel 1; an ack steps the acked channel and, on the last
// ack, the terminator; a stray ack, a tick after the transfer finished or an
// unused code only takes the request. A start first runs a bitwise restoring
// divider over the 32-bit file_length for the ack count, then sends a chunk
// on channel 0 and, with two channels, one on channel 1.
// A one-beat output register lets the next request in while a descriptor
// still waits; when the receiver stalls, the next emitting step waits for it.
// Reset clears all transfer state and loads the register defaults (1024-byte
// chunks, 1000-tick timeout); no clearing pass is needed.
// Depends on dcsw_pkg, dcsw_stream_if, dcsw_ctrl and dcsw_dp.
module dual_channel_stop_and_wait_sender_unit #(
	parameter int CHANNELS = dcsw_pkg::CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	dcsw_stream_if.sink req,
	dcsw_stream_if.source rsp,
	input logic cfg_we,
	input logic [dcsw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [dcsw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	dcsw_pkg::cmd_t cmd;
	dcsw_pkg::status_t st;
	dcsw_pkg::req_t req_data;
	dcsw_pkg::rsp_t rsp_data;
	logic req_ready;
	logic rsp_valid;

	assign req_data = req.data;
	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data = rsp_data;

	dcsw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req_ready),
		.st(st),
		.cmd(cmd)
	);

	dcsw_dp #(
		.CHANNELS(CHANNELS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_data(req_data),
		.out_valid(rsp_valid),
		.out_ready(rsp.ready),
		.out_data(rsp_data),
		.cmd(cmd),
		.st(st)
	);

endmodule
